@@ rtl/core/sil_pkg.sv @@
// ----------------------------------------------------------------------------
// sil_pkg
// shared types and constants of the sorted insertion list
// ----------------------------------------------------------------------------
package sil_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_READ
	} sil_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_key;
		logic insert;
		logic read;
	} sil_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic read_last;
	} sil_status_t;

endpackage

@@ rtl/core/sorted_insert_list.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_list
// sorted insertion list of signed q16.16 values with full readout per insert
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. In the next cycle it is
// inserted into the row of cells in a single step, after every stored value
// that is not greater (so equal values keep arrival order); a full list
// drops it. Then the list is read out lowest first, one result per cycle, by
// rotating the occupied cells; each result is registered from a readout state,
// so the first follows the insertion state and the first readout state; strobe
// marks each result, last marks the final one, and rejected is set on all of
// them when the value was dropped. Results cannot be held off. busy stays high
// from the insertion to the end of the readout, which gives one result per
// element of the list after the update. busy falls while the final result is
// shown, so the next value may be taken in that cycle.
// ----------------------------------------------------------------------------
module sorted_insert_list #(
	parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [sil_pkg::VALUE_W-1:0] value,
	output logic                              busy,
	output logic                              strobe,
	output logic signed [sil_pkg::VALUE_W-1:0] element,
	output logic [sil_pkg::POS_W-1:0]         position,
	output logic                              last,
	output logic                              rejected
);

	sil_pkg::sil_cmd_t    cmd;
	sil_pkg::sil_status_t status;

	// sequencing: idle, insert, readout
	sil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// cells, count and registered result
	sil_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.status   (status),
		.strobe   (strobe),
		.element  (element),
		.position (position),
		.last     (last),
		.rejected (rejected)
	);

endmodule

@@ rtl/core/sil_ctrl.sv @@
// ----------------------------------------------------------------------------
// sil_ctrl
// controller: accept, insertion cycle, then readout sequence
// ----------------------------------------------------------------------------
module sil_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sil_pkg::sil_status_t status,
	output sil_pkg::sil_cmd_t   cmd,
	output logic                busy
);

	sil_pkg::sil_state_t state_q;
	sil_pkg::sil_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sil_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sil_pkg::ST_IDLE: begin
				if (start) state_d = sil_pkg::ST_INSERT;
			end
			sil_pkg::ST_INSERT: begin
				state_d = sil_pkg::ST_READ;
			end
			sil_pkg::ST_READ: begin
				if (status.read_last) state_d = sil_pkg::ST_IDLE;
			end
			default: begin
				state_d = sil_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			sil_pkg::ST_IDLE: begin
				busy         = 1'b0;
				cmd.load_key = start;
			end
			sil_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
			end
			sil_pkg::ST_READ: begin
				cmd.read = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/core/sil_datapath.sv @@
// ----------------------------------------------------------------------------
// sil_datapath
// row of compare and shift cells, fill count, rotating readout
// ----------------------------------------------------------------------------
module sil_datapath #(
	parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sil_pkg::sil_cmd_t                 cmd,
	input  logic signed [sil_pkg::VALUE_W-1:0] value,
	output sil_pkg::sil_status_t              status,
	output logic                              strobe,
	output logic signed [sil_pkg::VALUE_W-1:0] element,
	output logic [sil_pkg::POS_W-1:0]         position,
	output logic                              last,
	output logic                              rejected
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic signed [sil_pkg::VALUE_W-1:0] cells_q [CAPACITY];
	logic signed [sil_pkg::VALUE_W-1:0] cells_d [CAPACITY];
	logic signed [sil_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0]                      count_q;
	logic [IW-1:0]                      idx_q;
	logic                               rej_q;
	logic [CAPACITY-1:0]                above;
	logic                               full;
	logic                               read_last;

	logic signed [sil_pkg::VALUE_W-1:0] element_q;
	logic [sil_pkg::POS_W-1:0]          position_q;
	logic                               last_q;
	logic                               rejected_q;
	logic                               strobe_q;

	assign full      = (count_q == CW'(CAPACITY));
	assign read_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign status.read_last = read_last;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			localparam logic [CW-1:0] NEXT_POS = CW'(gi + 1);
			logic signed [sil_pkg::VALUE_W-1:0] ins_src;
			logic signed [sil_pkg::VALUE_W-1:0] rot_src;

			// empty places count as greater than any key
			assign above[gi] = (CW'(gi) >= count_q) || (key_q < cells_q[gi]);

			if (gi == 0) begin : g_first
				assign ins_src = key_q;
			end else begin : g_rest
				assign ins_src = above[gi-1] ? cells_q[gi-1] : key_q;
			end

			if (gi == CAPACITY - 1) begin : g_top
				assign rot_src = cells_q[0];
			end else begin : g_mid
				assign rot_src = (NEXT_POS == count_q) ? cells_q[0] : cells_q[gi+1];
			end

			always_comb begin
				cells_d[gi] = cells_q[gi];
				if (cmd.insert && !full && above[gi]) begin
					cells_d[gi] = ins_src;
				end else if (cmd.read && (NEXT_POS <= count_q)) begin
					cells_d[gi] = rot_src;
				end
			end
		end
	endgenerate

	// payload
	always_ff @(posedge clk) begin
		cells_q <= cells_d;
		if (cmd.load_key) key_q <= value;
		if (cmd.read) begin
			element_q  <= cells_q[0];
			position_q <= sil_pkg::POS_W'(idx_q);
			last_q     <= read_last;
			rejected_q <= rej_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			rej_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.read;
			if (cmd.insert) begin
				rej_q <= full;
				idx_q <= '0;
				if (!full) count_q <= count_q + CW'(1);
			end else if (cmd.read) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign strobe   = strobe_q;
	assign element  = element_q;
	assign position = position_q;
	assign last     = last_q;
	assign rejected = rejected_q;

endmodule

@@ rtl/core/sil_checker.sv @@
// ----------------------------------------------------------------------------
// sil_checker
// port level checks of the readout sequence
// ----------------------------------------------------------------------------
module sil_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              strobe,
	input logic [sil_pkg::POS_W-1:0]         position,
	input logic                              last,
	input logic                              rejected
);

	// a readout in progress keeps the block busy
	a_busy_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("busy low during readout");

	// a transfer is followed by the insertion cycle with no result
	a_insert_gap: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("result right after transfer");

	// results of one readout come back to back with rising position
	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (position == sil_pkg::POS_W'($past(position) + 1'b1)))
		else $error("readout gap or position skip");

	// rejected flag is the same over one readout
	a_rejected_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> rejected == $past(rejected))
		else $error("rejected changed within readout");

	// readout ends after last
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result after last");

endmodule

bind sorted_insert_list sil_checker u_sil_checker (.*);

@@ tb/sil_list_checker.sv @@
// ----------------------------------------------------------------------------
// sil_list_checker
// watches the sorted insertion list, predicts every readout and compares it
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the sorted list. Each value taken by the block is
// inserted into that copy, and the full readout it should cause is queued.
// Each strobed result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module sil_list_checker #(
	parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [sil_pkg::VALUE_W-1:0] value,
	input  logic                               busy,
	input  logic                               strobe,
	input  logic signed [sil_pkg::VALUE_W-1:0] element,
	input  logic [sil_pkg::POS_W-1:0]          position,
	input  logic                               last,
	input  logic                               rejected,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 elements_checked,
	output int                                 dropped_inputs
);

	typedef struct {
		logic signed [sil_pkg::VALUE_W-1:0] element;
		logic [sil_pkg::POS_W-1:0]          position;
		logic                               last;
		logic                               rejected;
	} readout_t;

	logic signed [sil_pkg::VALUE_W-1:0] shadow_list [CAPACITY];
	int                                 shadow_len;
	readout_t                           readout_q [$];

	// insert into the shadow list, then queue the whole readout
	task automatic predict_insert(input logic signed [sil_pkg::VALUE_W-1:0] key);
		int       slot;
		logic     dropped;
		readout_t entry;
		dropped = (shadow_len >= CAPACITY);
		if (!dropped) begin
			slot = shadow_len;
			while (slot > 0 && key < shadow_list[slot-1]) begin
				shadow_list[slot] = shadow_list[slot-1];
				slot--;
			end
			shadow_list[slot] = key;
			shadow_len++;
		end else begin
			dropped_inputs++;
		end
		for (int k = 0; k < shadow_len; k++) begin
			entry.element  = shadow_list[k];
			entry.position = sil_pkg::POS_W'(k);
			entry.last     = (k == shadow_len - 1);
			entry.rejected = dropped;
			readout_q.push_back(entry);
		end
	endtask

	task automatic check_element();
		readout_t want;
		if (readout_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: element=%0d position=%0d last=%b rejected=%b",
					element, position, last, rejected);
			return;
		end
		want = readout_q.pop_front();
		elements_checked++;
		if (element !== want.element || position !== want.position ||
				last !== want.last || rejected !== want.rejected) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected element=%0d position=%0d last=%b rejected=%b, ",
					want.element, want.position, want.last, want.rejected,
					"got element=%0d position=%0d last=%b rejected=%b",
					element, position, last, rejected);
		end
	endtask

	// a result of an earlier insert may share the edge with a new transfer,
	// so results are matched before the new readout is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len       = 0;
			readout_q.delete();
			mismatches       = 0;
			pending          = 0;
			elements_checked = 0;
			dropped_inputs   = 0;
		end else begin
			if (strobe !== 1'b0)
				check_element();
			if (start && busy === 1'b0)
				predict_insert(value);
			pending = readout_q.size();
		end
	end

endmodule

@@ tb/sorted_insert_list_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_list_tb
// self-checking testbench of the sorted insertion list
// ----------------------------------------------------------------------------
// Fills the list with a directed set of extreme, equal and ordinary values,
// then keeps sending random values to the full list so that every readout
// carries the rejected flag in three phases; the sender idles at random in
// all but the last. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_insert_list_tb;

	localparam int CAPACITY     = sil_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 71;
	localparam int DIRECTED_NUM = 18;
	// cycles after the last expected result before the verdict
	localparam int TAIL_CYCLES  = 2 * CAPACITY + 4;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic signed [sil_pkg::VALUE_W-1:0] value;
	logic                               busy;
	logic                               strobe;
	logic signed [sil_pkg::VALUE_W-1:0] element;
	logic [sil_pkg::POS_W-1:0]          position;
	logic                               last;
	logic                               rejected;

	int mismatches;
	int pending;
	int elements_checked;
	int dropped_inputs;
	int items_sent;
	int idle_pct;
	int cycle_count;

	// directed fill: both extremes, zero, plus and minus one lsb, plus and
	// minus one in q16.16, and repeats that must land after their equals;
	// the first sixteen fill the list, the last two hit a full list
	logic signed [sil_pkg::VALUE_W-1:0] directed_vals [DIRECTED_NUM] = '{
		32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
		32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000, 32'shFFFF_0000,
		32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000, 32'sh7FFF_FFFE,
		32'sh8000_0001, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
		32'sh0000_0000, 32'sh7FFF_FFFF
	};

	sorted_insert_list #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.busy    (busy),
		.strobe  (strobe),
		.element (element),
		.position(position),
		.last    (last),
		.rejected(rejected)
	);

	sil_list_checker #(
		.CAPACITY(CAPACITY)
	) u_list_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.value           (value),
		.busy            (busy),
		.strobe          (strobe),
		.element         (element),
		.position        (position),
		.last            (last),
		.rejected        (rejected),
		.mismatches      (mismatches),
		.pending         (pending),
		.elements_checked(elements_checked),
		.dropped_inputs  (dropped_inputs)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a hang or a missing result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one transfer: random idle cycles first, then hold start until the block
	// takes the value; called and returning at a falling edge, so start gets
	// one assignment per time step
	task automatic send_value(input logic signed [sil_pkg::VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		// busy seen at the edge is the pre-edge value, so low means taken
		while (busy !== 1'b0)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// hold off until every expected result has come back
	task automatic drain_readouts();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// random value: mostly full-range, sometimes near the extremes or zero
	function automatic logic signed [sil_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			1:       return 32'sh8000_0000 + $urandom_range(0, 3);
			2:       return $urandom_range(0, 8) - 4;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		value      = '0;
		items_sent = 0;
		idle_pct   = 35;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed fill, with one full pause halfway
		for (int i = 0; i < DIRECTED_NUM; i++) begin
			send_value(directed_vals[i]);
			if (i == DIRECTED_NUM / 2)
				drain_readouts();
		end

		// random part in three phases, the last without idle cycles; the list is full
		// by now, so every readout is the whole list with rejected set
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 35 : (phase == 1) ? 50 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_value(pick_value());
				if (phase == 1 && i == PHASE_ITEMS / 2)
					drain_readouts();
			end
		end

		drain_readouts();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("run covered %0d values (%0d dropped on a full list), %0d list elements checked",
			items_sent, dropped_inputs, elements_checked);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sil_pkg.sv
rtl/core/sil_ctrl.sv
rtl/core/sil_datapath.sv
rtl/core/sorted_insert_list.sv
rtl/core/sil_checker.sv
tb/sil_list_checker.sv
tb/sorted_insert_list_tb.sv
